// ===== hw/rtl/npd_pkg.sv =====
// Shared types and constants for the node pair distance block.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package npd_pkg;

    localparam int METRIC_W = 3;
    localparam int DIST_W   = 18;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [METRIC_W-1:0] {
        EUC_2D = 3'd0,
        EUC_3D = 3'd1,
        MAN_2D = 3'd2,
        MAN_3D = 3'd3,
        MAX_2D = 3'd4,
        MAX_3D = 3'd5
    } t_metric;

endpackage

`default_nettype wire

// ===== hw/rtl/npd_if.sv =====
// Valid/ready channel interfaces: node pair coordinates in, distance out.
// Depends on npd_pkg for the distance width.
`default_nettype none

interface npd_pair_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by_coord, bz, output ready);
endinterface

interface npd_dist_if;
    import npd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/npd_front.sv =====
// Front end: absolute differences, squares and linear metric, sum of squares.
// Three register stages with per-stage valid/ready. Depends on npd_pkg.
`default_nettype none

module npd_front #(
    parameter int COORD_BITS = 24
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  signed [COORD_BITS-1:0]          i_ax,
    input  wire  signed [COORD_BITS-1:0]          i_ay,
    input  wire  signed [COORD_BITS-1:0]          i_az,
    input  wire  signed [COORD_BITS-1:0]          i_bx,
    input  wire  signed [COORD_BITS-1:0]          i_by,
    input  wire  signed [COORD_BITS-1:0]          i_bz,
    input  npd_pkg::t_metric                      i_metric,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic [2*(COORD_BITS+1)+3:0]           o_rad,
    output logic [COORD_BITS+2:0]                 o_lin,
    output npd_pkg::t_metric                      o_metric
);
    import npd_pkg::*;

    localparam int D  = COORD_BITS + 1;   // magnitude of a difference
    localparam int LW = D + 2;            // linear metric value
    localparam int QW = 2 * D;            // one square
    localparam int SW = 2 * D + 2;        // sum of three squares
    localparam int W  = 2 * D + 4;        // radicand, 4 * sum

    function automatic logic [D-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                              input logic signed [COORD_BITS-1:0] b);
        logic signed [D-1:0] d;
        d = D'(a) - D'(b);
        return d[D-1] ? D'(-d) : D'(d);
    endfunction

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    logic [D-1:0]  r_dx, r_dy, r_dz;
    t_metric       r_m1, r_m2;
    logic [QW-1:0] r_sqx, r_sqy, r_sqz;
    logic [LW-1:0] r_lin2, r_lin3;
    logic [W-1:0]  r_rad;
    t_metric       r_m3;

    logic          is_3d, is_max;
    logic [D-1:0]  w_dz;
    logic [D-1:0]  w_mxy, w_max;
    logic [LW-1:0] w_lin;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign is_3d = r_m1 inside {EUC_3D, MAN_3D, MAX_3D};
    assign is_max = r_m1 inside {MAX_2D, MAX_3D};
    assign w_dz  = is_3d ? r_dz : '0;
    assign w_mxy = (r_dx > r_dy) ? r_dx : r_dy;
    assign w_max = (w_dz > w_mxy) ? w_dz : w_mxy;
    assign w_lin = is_max ? LW'(w_max) : (LW'(r_dx) + LW'(r_dy) + LW'(w_dz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_dx <= abs_diff(i_ax, i_bx);
            r_dy <= abs_diff(i_ay, i_by);
            r_dz <= abs_diff(i_az, i_bz);
            r_m1 <= i_metric;
        end
        if (rdy2) begin
            r_sqx  <= QW'(r_dx) * QW'(r_dx);
            r_sqy  <= QW'(r_dy) * QW'(r_dy);
            r_sqz  <= QW'(w_dz) * QW'(w_dz);
            r_lin2 <= w_lin;
            r_m2   <= r_m1;
        end
        if (rdy3) begin
            r_rad  <= {SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz), 2'b00};
            r_lin3 <= r_lin2;
            r_m3   <= r_m2;
        end
    end

    assign o_valid  = r_v3;
    assign o_rad    = r_rad;
    assign o_lin    = r_lin3;
    assign o_metric = r_m3;

endmodule

`default_nettype wire

// ===== hw/rtl/npd_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Side data travels with each radicand. Depends on npd_pkg only by convention.
`default_nettype none

module npd_isqrt #(
    parameter int W      = 54,
    parameter int SIDE_W = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [W-1:0]        i_rad,
    input  wire  [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [W/2-1:0]      o_root,
    output logic [SIDE_W-1:0]   o_side
);
    import npd_pkg::*;

    localparam int N  = W / 2;
    localparam int RW = N + 2;

    logic [N:0]        rdy;
    logic              r_v    [N];
    logic [RW-1:0]     r_rem  [N];
    logic [N-1:0]      r_root [N];
    logic [W-1:0]      r_rad  [N];
    logic [SIDE_W-1:0] r_side [N];

    assign rdy[N] = i_ready;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            localparam int P = N - 1 - k;   // bit pair consumed here

            logic              v_in;
            logic [RW-1:0]     rem_in;
            logic [N-1:0]      root_in;
            logic [W-1:0]      rad_in;
            logic [SIDE_W-1:0] side_in;
            logic [RW-1:0]     rem_sh, trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign v_in    = i_valid;
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = i_rad;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_v[k-1];
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign rad_in  = r_rad[k-1];
                assign side_in = r_side[k-1];
            end

            assign rdy[k] = !r_v[k] || rdy[k+1];
            assign rem_sh = {rem_in[RW-3:0], rad_in[2*P+1:2*P]};
            assign trial  = {root_in, 2'b01};
            assign ge     = rem_sh >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_v[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[k]) begin
                    r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_root[k] <= {root_in[N-2:0], ge};
                    r_rad[k]  <= rad_in;
                    r_side[k] <= side_in;
                end
            end
        end
    endgenerate

    assign o_ready = rdy[0];
    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/npd_round.sv =====
// Output stage: picks root or linear value, rounds halves up, saturates.
// Holds the result register facing the output channel; an unknown metric gives zero. Depends on npd_pkg.
`default_nettype none

module npd_round #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [COORD_BITS+2:0]        i_root,
    input  wire  [COORD_BITS+2:0]        i_lin,
    input  npd_pkg::t_metric             i_metric,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [npd_pkg::DIST_W-1:0]   o_distance
);
    import npd_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int VW = D + 3;
    localparam int XW = VW + FRAC_BITS + DIST_W + 1;

    logic              r_v;
    logic [DIST_W-1:0] r_dist;

    logic              is_euc, is_known;
    logic [VW-1:0]     w_val;
    logic [XW-1:0]     w_sum, w_shift;
    logic [DIST_W-1:0] n_dist;

    assign is_euc   = i_metric inside {EUC_2D, EUC_3D};
    assign is_known = i_metric inside {EUC_2D, EUC_3D, MAN_2D, MAN_3D, MAX_2D, MAX_3D};

    // Root is already twice the real distance; scale the linear value to match.
    assign w_val   = is_euc ? VW'(i_root) : {i_lin, 1'b0};
    assign w_sum   = XW'(w_val) + (XW'(1) << FRAC_BITS);
    assign w_shift = w_sum >> (FRAC_BITS + 1);

    always_comb begin
        if (!is_known) begin
            n_dist = '0;
        end else if (w_shift > XW'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = w_shift[DIST_W-1:0];
        end
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_dist <= n_dist;
        end
    end

    assign o_valid    = r_v;
    assign o_distance = r_dist;

endmodule

`default_nettype wire

// ===== hw/rtl/node_pair_distance.sv =====
// Node pair distance: three front stages, one square root stage per root bit,
// one output stage. Throughput one pair per cycle when the output is not
// stalled; every stage holds its own beat under stall.
// Synchronous active-low reset empties the pipeline and sets the metric to EUC_2D.
`default_nettype none

module node_pair_distance #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [npd_pkg::METRIC_W-1:0]    i_cfg_wdata,
    npd_pair_if.sink                        i_pair,
    npd_dist_if.source                      o_dist
);
    import npd_pkg::*;

    localparam int D      = COORD_BITS + 1;
    localparam int W      = 2 * D + 4;
    localparam int LW     = D + 2;
    localparam int SIDE_W = LW + METRIC_W;

    t_metric r_metric;

    logic          f_valid, f_ready;
    logic [W-1:0]  f_rad;
    logic [LW-1:0] f_lin;
    t_metric       f_metric;

    logic              s_valid, s_ready;
    logic [W/2-1:0]    s_root;
    logic [SIDE_W-1:0] s_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= EUC_2D;
        end else if (i_cfg_we) begin
            r_metric <= t_metric'(i_cfg_wdata);
        end
    end

    npd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pair.valid),
        .o_ready  (i_pair.ready),
        .i_ax     (i_pair.ax),
        .i_ay     (i_pair.ay),
        .i_az     (i_pair.az),
        .i_bx     (i_pair.bx),
        .i_by     (i_pair.by_coord),
        .i_bz     (i_pair.bz),
        .i_metric (r_metric),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_rad    (f_rad),
        .o_lin    (f_lin),
        .o_metric (f_metric)
    );

    npd_isqrt #(
        .W      (W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_rad   (f_rad),
        .i_side  ({f_lin, f_metric}),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    npd_round #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_valid),
        .o_ready    (s_ready),
        .i_root     (s_root),
        .i_lin      (s_side[SIDE_W-1:METRIC_W]),
        .i_metric   (t_metric'(s_side[METRIC_W-1:0])),
        .o_valid    (o_dist.valid),
        .i_ready    (o_dist.ready),
        .o_distance (o_dist.distance)
    );

`ifndef ASSERT_OFF
    // No result may leave in the cycle after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_dist.valid)
        else $error("result beat right after reset");

    // A draining output must let the whole pipeline move.
    a_flow_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist.ready |-> i_pair.ready)
        else $error("input stalled while output drains");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_metric == t_metric'($past(i_cfg_wdata))))
        else $error("metric register missed a write");
`endif

endmodule

`default_nettype wire
